@@ hw/rtl/v3a_pkg.sv @@
`timescale 1ns / 1ps

package v3a_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int ROOT_W      = DATA_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int LEN_W       = ROOT_W + 1;
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int NUM_W       = DATA_W + FRAC_BITS + 2;
    localparam int DEN_W       = LEN_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_SUB    = 3'd1;
    localparam logic [2:0] MODE_SCALE  = 3'd2;
    localparam logic [2:0] MODE_DOT    = 3'd3;
    localparam logic [2:0] MODE_LENGTH = 3'd4;
    localparam logic [2:0] MODE_NORM   = 3'd5;
    localparam logic [2:0] MODE_CROSS  = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] scalar;
    } v3a_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_x;
        logic signed [DATA_W-1:0] res_y;
        logic signed [DATA_W-1:0] res_z;
        logic [1:0]               status;
    } v3a_result_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic [2:0][DATA_W-1:0]  a;
        logic [2:0][DATA_W-1:0]  b;
        logic [5:0][PROD_W-1:0]  prod;
    } v3a_item_t;

endpackage

@@ hw/rtl/v3a_front.sv @@
`timescale 1ns / 1ps

module v3a_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  v3a_pkg::v3a_cmd_t   cmd,
    input  logic                queue_full,
    output logic                item_valid,
    output v3a_pkg::v3a_item_t  item
);
    import v3a_pkg::*;

    logic                     take;
    logic                     valid_reg;
    logic                     valid_next;
    v3a_item_t                item_reg;
    v3a_item_t                item_next;
    logic signed [DATA_W-1:0] op_a [6];
    logic signed [DATA_W-1:0] op_b [6];
    logic signed [PROD_W-1:0] prod [6];

    assign busy       = queue_full;
    assign take       = start & ~queue_full;
    assign valid_next = take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (cmd.mode) inside
            MODE_SCALE:
            begin
                op_a[0] = cmd.scalar; op_b[0] = cmd.b_x;
                op_a[1] = cmd.scalar; op_b[1] = cmd.b_y;
                op_a[2] = cmd.scalar; op_b[2] = cmd.b_z;
            end
            MODE_LENGTH, MODE_NORM:
            begin
                op_a[0] = cmd.a_x; op_b[0] = cmd.a_x;
                op_a[1] = cmd.a_y; op_b[1] = cmd.a_y;
                op_a[2] = cmd.a_z; op_b[2] = cmd.a_z;
            end
            MODE_CROSS:
            begin
                op_a[0] = cmd.a_y; op_b[0] = cmd.b_z;
                op_a[3] = cmd.a_z; op_b[3] = cmd.b_y;
                op_a[1] = cmd.a_z; op_b[1] = cmd.b_x;
                op_a[4] = cmd.a_x; op_b[4] = cmd.b_z;
                op_a[2] = cmd.a_x; op_b[2] = cmd.b_y;
                op_a[5] = cmd.a_y; op_b[5] = cmd.b_x;
            end
            default:
            begin
                op_a[0] = cmd.a_x; op_b[0] = cmd.b_x;
                op_a[1] = cmd.a_y; op_b[1] = cmd.b_y;
                op_a[2] = cmd.a_z; op_b[2] = cmd.b_z;
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            prod[i] = op_a[i] * op_b[i];
        end
        item_next.mode = cmd.mode;
        item_next.a[0] = cmd.a_x;
        item_next.a[1] = cmd.a_y;
        item_next.a[2] = cmd.a_z;
        item_next.b[0] = cmd.b_x;
        item_next.b[1] = cmd.b_y;
        item_next.b[2] = cmd.b_z;
        for (int i = 0; i < 6; i++)
        begin
            item_next.prod[i] = prod[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hw/rtl/v3a_queue.sv @@
`timescale 1ns / 1ps

module v3a_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  v3a_pkg::v3a_item_t  push_data,
    output logic                full,
    output logic                out_valid,
    output v3a_pkg::v3a_item_t  out_data
);
    import v3a_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    v3a_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             out_valid_reg;
    v3a_item_t        out_data_reg;
    logic             pop;

    assign pop         = (count_reg != '0);
    assign full        = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
    assign count_next  = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= pop;
        end
    end

endmodule

@@ hw/rtl/v3a_back.sv @@
`timescale 1ns / 1ps

module v3a_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  v3a_pkg::v3a_item_t   item,
    output logic                 done,
    output v3a_pkg::v3a_result_t result
);
    import v3a_pkg::*;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [2:0]             mode;
        logic [2:0][DATA_W-1:0] as_val;
        logic                   as_sat;
        logic [2:0][SUM_W-1:0]  v;
        logic [PROD_W-1:0]      s;
        logic [2:0][DATA_W-1:0] mag;
        logic [2:0]             neg;
    } v3a_stage1_t;

    typedef struct packed {
        logic [2:0]             mode;
        v3a_result_t            res;
        logic [2:0][DATA_W-1:0] mag;
        logic [2:0]             neg;
        logic [LEN_W-1:0]       len;
    } v3a_carry_t;

    // operand stage
    logic                    b1_valid_reg;
    v3a_stage1_t             b1_reg;
    v3a_stage1_t             b1_next;
    logic [DATA_W:0]         as_e [3];
    logic signed [SUM_W-1:0] p_ext [6];
    logic signed [SUM_W-1:0] sum3;

    always_comb
    begin
        b1_next.mode   = item.mode;
        b1_next.as_sat = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            p_ext[i] = SUM_W'($signed(item.prod[i]));
        end
        sum3 = p_ext[0] + p_ext[1] + p_ext[2];
        b1_next.s = sum3[PROD_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            if (item.mode == MODE_SUB)
            begin
                as_e[i] = {item.a[i][DATA_W-1], item.a[i]} - {item.b[i][DATA_W-1], item.b[i]};
            end
            else
            begin
                as_e[i] = {item.a[i][DATA_W-1], item.a[i]} + {item.b[i][DATA_W-1], item.b[i]};
            end
            if (as_e[i][DATA_W] != as_e[i][DATA_W-1])
            begin
                b1_next.as_val[i] = as_e[i][DATA_W] ? MIN_VAL : MAX_VAL;
                b1_next.as_sat    = 1'b1;
            end
            else
            begin
                b1_next.as_val[i] = as_e[i][DATA_W-1:0];
            end
            case (item.mode)
                MODE_CROSS: b1_next.v[i] = p_ext[i] - p_ext[i + 3];
                MODE_DOT:   b1_next.v[i] = (i == 0) ? sum3 : '0;
                default:    b1_next.v[i] = p_ext[i];
            endcase
            b1_next.neg[i] = item.a[i][DATA_W-1];
            b1_next.mag[i] = item.a[i][DATA_W-1] ? DATA_W'(-item.a[i]) : item.a[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg <= b1_next;
    end

    // rounding of products and selection of the short-path result
    logic signed [SUM_W-1:0] rsum [3];
    logic signed [SUM_W-1:0] rsh [3];
    logic [DATA_W-1:0]       rl [3];
    logic                    rsat [3];
    v3a_carry_t              b2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = $signed(b1_reg.v[i]) + RND_HALF;
            rsh[i]  = rsum[i] >>> FRAC_BITS;
            if ((&rsh[i][SUM_W-1:DATA_W-1]) || !(|rsh[i][SUM_W-1:DATA_W-1]))
            begin
                rl[i]   = rsh[i][DATA_W-1:0];
                rsat[i] = 1'b0;
            end
            else
            begin
                rl[i]   = rsh[i][SUM_W-1] ? MIN_VAL : MAX_VAL;
                rsat[i] = 1'b1;
            end
        end
        b2_next.mode = b1_reg.mode;
        b2_next.mag  = b1_reg.mag;
        b2_next.neg  = b1_reg.neg;
        b2_next.len  = '0;
        b2_next.res  = '0;
        case (b1_reg.mode) inside
            MODE_ADD, MODE_SUB:
            begin
                b2_next.res.res_x  = b1_reg.as_val[0];
                b2_next.res.res_y  = b1_reg.as_val[1];
                b2_next.res.res_z  = b1_reg.as_val[2];
                b2_next.res.status = b1_reg.as_sat ? ST_SAT : ST_OK;
            end
            MODE_SCALE, MODE_CROSS:
            begin
                b2_next.res.res_x  = rl[0];
                b2_next.res.res_y  = rl[1];
                b2_next.res.res_z  = rl[2];
                b2_next.res.status = (rsat[0] | rsat[1] | rsat[2]) ? ST_SAT : ST_OK;
            end
            MODE_DOT:
            begin
                b2_next.res.res_x  = rl[0];
                b2_next.res.status = rsat[0] ? ST_SAT : ST_OK;
            end
            default:
            begin
                b2_next.res = '0;
            end
        endcase
    end

    // square root, one result bit per stage
    logic              sq_valid_reg [ROOT_W];
    v3a_carry_t        sq_carry_reg [ROOT_W];
    logic [PROD_W-1:0] sq_s_reg     [ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        logic              valid_in;
        v3a_carry_t        carry_in;
        logic [PROD_W-1:0] s_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [PROD_W-1:0] s_next;

        if (g == 0)
        begin : g_head
            assign valid_in = b1_valid_reg;
            assign carry_in = b2_next;
            assign s_in     = b1_reg.s;
            assign rem_in   = '0;
            assign root_in  = '0;
        end
        else
        begin : g_body
            assign valid_in = sq_valid_reg[g-1];
            assign carry_in = sq_carry_reg[g-1];
            assign s_in     = sq_s_reg[g-1];
            assign rem_in   = sq_rem_reg[g-1];
            assign root_in  = sq_root_reg[g-1];
        end

        assign rem_sh    = {rem_in, s_in[PROD_W-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign diff      = rem_sh - trial;
        assign rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        assign root_next = {root_in[ROOT_W-2:0], ge};
        assign s_next    = {s_in[PROD_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[g] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_carry_reg[g] <= carry_in;
            sq_s_reg[g]     <= s_next;
            sq_rem_reg[g]   <= rem_next;
            sq_root_reg[g]  <= root_next;
        end
    end

    // round the root to nearest
    logic             r_valid_reg;
    v3a_carry_t       r_carry_reg;
    v3a_carry_t       r_carry_next;
    logic [LEN_W-1:0] len;

    always_comb
    begin
        len = LEN_W'(sq_root_reg[ROOT_W-1])
            + LEN_W'(sq_rem_reg[ROOT_W-1] > REM_W'(sq_root_reg[ROOT_W-1]));
        r_carry_next     = sq_carry_reg[ROOT_W-1];
        r_carry_next.len = len;
        if (sq_carry_reg[ROOT_W-1].mode == MODE_LENGTH)
        begin
            if (len > LEN_W'(MAX_VAL))
            begin
                r_carry_next.res.res_x  = MAX_VAL;
                r_carry_next.res.status = ST_SAT;
            end
            else
            begin
                r_carry_next.res.res_x  = len[DATA_W-1:0];
                r_carry_next.res.status = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= sq_valid_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r_carry_reg <= r_carry_next;
    end

    // restoring division of each magnitude by the length, one quotient bit per stage
    logic                   dv_valid_reg [QUO_W];
    v3a_carry_t             dv_carry_reg [QUO_W];
    logic [2:0][NUM_W-1:0]  dv_rem_reg   [QUO_W];
    logic [2:0][QUO_W-1:0]  dv_quo_reg   [QUO_W];

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        localparam int SH = FRAC_BITS - g;

        logic                  valid_in;
        v3a_carry_t            carry_in;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [NUM_W-1:0]      dsh;
        logic [2:0]            ge;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] quo_next;

        if (g == 0)
        begin : g_head
            assign valid_in = r_valid_reg;
            assign carry_in = r_carry_reg;
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign rem_in[k] = NUM_W'({r_carry_reg.mag[k], {QUO_W{1'b0}}})
                                 + NUM_W'(r_carry_reg.len);
                assign quo_in[k] = '0;
            end
        end
        else
        begin : g_body
            assign valid_in = dv_valid_reg[g-1];
            assign carry_in = dv_carry_reg[g-1];
            assign rem_in   = dv_rem_reg[g-1];
            assign quo_in   = dv_quo_reg[g-1];
        end

        assign dsh = NUM_W'({carry_in.len, 1'b0}) << SH;

        for (genvar k = 0; k < 3; k++)
        begin : g_step
            assign ge[k]       = (rem_in[k] >= dsh);
            assign rem_next[k] = ge[k] ? (rem_in[k] - dsh) : rem_in[k];
            assign quo_next[k] = {quo_in[k][QUO_W-2:0], ge[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[g] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_carry_reg[g] <= carry_in;
            dv_rem_reg[g]   <= rem_next;
            dv_quo_reg[g]   <= quo_next;
        end
    end

    // final selection
    logic              done_reg;
    v3a_result_t       res_reg;
    v3a_result_t       res_next;
    logic [DATA_W-1:0] nq [3];
    logic [DATA_W-1:0] nv [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nq[i] = DATA_W'(dv_quo_reg[QUO_W-1][i]);
            nv[i] = dv_carry_reg[QUO_W-1].neg[i] ? DATA_W'(-nq[i]) : nq[i];
        end
        res_next = dv_carry_reg[QUO_W-1].res;
        if (dv_carry_reg[QUO_W-1].mode == MODE_NORM)
        begin
            if (dv_carry_reg[QUO_W-1].len == '0)
            begin
                res_next        = '0;
                res_next.status = ST_ZERO;
            end
            else
            begin
                res_next.res_x  = nv[0];
                res_next.res_y  = nv[1];
                res_next.res_z  = nv[2];
                res_next.status = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QUO_W-1] |=> done_reg)
        else $error("result strobe lost");

    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.status == ST_ZERO) |->
        (res_reg.res_x == '0 && res_reg.res_y == '0 && res_reg.res_z == '0))
        else $error("zero-length result not cleared");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[ROOT_W-1] |->
        (sq_rem_reg[ROOT_W-1] <= REM_W'({sq_root_reg[ROOT_W-1], 1'b0})))
        else $error("root remainder out of range");

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QUO_W-1] && dv_carry_reg[QUO_W-1].mode == MODE_NORM
         && dv_carry_reg[QUO_W-1].len != '0) |->
        (dv_quo_reg[QUO_W-1][0] <= (QUO_W'(1) << FRAC_BITS)
         && dv_quo_reg[QUO_W-1][1] <= (QUO_W'(1) << FRAC_BITS)
         && dv_quo_reg[QUO_W-1][2] <= (QUO_W'(1) << FRAC_BITS)))
        else $error("normalized component above one");

endmodule

@@ hw/rtl/vector3_alu_unit.sv @@
`timescale 1ns / 1ps
// Three-dimensional vector unit on signed fixed point (FRAC_BITS fraction bits).
// Command channel: drive cmd and raise start; the transaction is taken at a
// rising edge where start is high and busy is low. busy rises only when the
// queue between the front end and the execution pipeline is full, which does
// not happen in steady operation, so one transaction per cycle is accepted.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, it cannot stall the unit.
// Every mode passes through the same path, so results leave in order: the
// multiplier stage and the queue, then the square-root pipeline (one root bit
// per stage, 32 stages), then the normalize divider (one quotient bit per
// stage, FRAC_BITS + 1 stages).
// Throughput: one transaction per clock cycle.
// Reset: rst_n clears all valid flags and the queue; no result is produced
// until a new transaction is accepted.
module vector3_alu_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  v3a_pkg::v3a_cmd_t    cmd,
    output logic                 done,
    output v3a_pkg::v3a_result_t result
);
    import v3a_pkg::*;

    logic      queue_full;
    logic      front_valid;
    v3a_item_t front_item;
    logic      queue_valid;
    v3a_item_t queue_item;

    v3a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .queue_full (queue_full),
        .item_valid (front_valid),
        .item       (front_item)
    );

    v3a_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_item),
        .full      (queue_full),
        .out_valid (queue_valid),
        .out_data  (queue_item)
    );

    v3a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .done       (done),
        .result     (result)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import v3a_pkg::*;

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 1430;
    localparam int CALM_TAIL  = 150;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 80;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    v3a_cmd_t    cmd;
    logic        done;
    v3a_result_t result;

    vector3_alu_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    v3a_result_t pending_results[$];
    v3a_result_t typed_result;
    logic        use_typed;
    int          error_count;
    int          cycle_count;
    int          results_seen;
    int          mode_hits[8];

    v3a_cmd_t    row_cmd[N_DIRECTED];
    logic        row_typed[N_DIRECTED];
    v3a_result_t row_result[N_DIRECTED];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic hit);
        if (v > 128'sd2147483647)
        begin
            hit = 1'b1;
            return MAX_VAL;
        end
        if (v < -128'sd2147483648)
        begin
            hit = 1'b1;
            return MIN_VAL;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [127:0] round_frac(input logic signed [127:0] p);
        return (p + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic [63:0] vec_length(input logic signed [127:0] a[3]);
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] m;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
            sq += m * m;
        end
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > sq)
            bitv >>= 2;
        for (logic [63:0] rem = sq; bitv != 0; bitv >>= 2)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
        end
        if (sq - root * root > root)
            root++;
        return root;
    endfunction

    function automatic v3a_result_t vec_result(input v3a_cmd_t c);
        v3a_result_t r;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] s;
        logic signed [127:0] v;
        logic [63:0] len;
        logic [63:0] m;
        logic [63:0] quo;
        logic [31:0] o[3];
        logic hit;
        a[0] = c.a_x; a[1] = c.a_y; a[2] = c.a_z;
        b[0] = c.b_x; b[1] = c.b_y; b[2] = c.b_z;
        s = c.scalar;
        o[0] = 0; o[1] = 0; o[2] = 0;
        hit = 1'b0;
        r.status = ST_OK;
        case (c.mode)
            MODE_ADD:
                for (int i = 0; i < 3; i++)
                    o[i] = clamp32(a[i] + b[i], hit);
            MODE_SUB:
                for (int i = 0; i < 3; i++)
                    o[i] = clamp32(a[i] - b[i], hit);
            MODE_SCALE:
                for (int i = 0; i < 3; i++)
                    o[i] = clamp32(round_frac(s * b[i]), hit);
            MODE_DOT:
                o[0] = clamp32(round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), hit);
            MODE_LENGTH:
            begin
                len = vec_length(a);
                o[0] = clamp32(128'(len), hit);
            end
            MODE_NORM:
            begin
                len = vec_length(a);
                if (len == 0)
                    r.status = ST_ZERO;
                else
                    for (int i = 0; i < 3; i++)
                    begin
                        m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
                        quo = ((m << (FRAC_BITS + 1)) + len) / (2 * len);
                        if (quo > 64'h8000_0000)
                            quo = 64'h8000_0000;
                        v = quo;
                        o[i] = clamp32((a[i] < 0) ? -v : v, hit);
                    end
            end
            MODE_CROSS:
            begin
                o[0] = clamp32(round_frac(a[1] * b[2] - a[2] * b[1]), hit);
                o[1] = clamp32(round_frac(a[2] * b[0] - a[0] * b[2]), hit);
                o[2] = clamp32(round_frac(a[0] * b[1] - a[1] * b[0]), hit);
            end
            default:
                ;
        endcase
        if (hit)
            r.status = ST_SAT;
        r.res_x = o[0];
        r.res_y = o[1];
        r.res_z = o[2];
        return r;
    endfunction

    function automatic v3a_cmd_t make_cmd(input logic [2:0] mode, input logic [31:0] ax,
                                          input logic [31:0] ay, input logic [31:0] az,
                                          input logic [31:0] bx, input logic [31:0] by,
                                          input logic [31:0] bz, input logic [31:0] s);
        v3a_cmd_t c;
        c.mode = mode;
        c.a_x = ax; c.a_y = ay; c.a_z = az;
        c.b_x = bx; c.b_y = by; c.b_z = bz;
        c.scalar = s;
        return c;
    endfunction

    function automatic v3a_result_t make_result(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z, input logic [1:0] st);
        v3a_result_t r;
        r.res_x = x; r.res_y = y; r.res_z = z; r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return MAX_VAL;
            1: return MIN_VAL;
            2: return 32'($urandom_range(0, 3)) - 32'd1;
            3, 4, 5: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            6, 7: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input v3a_cmd_t c, input logic typed, input v3a_result_t r);
        cmd = c;
        use_typed = typed;
        typed_result = r;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_burst();
        start = 1'b0;
        cmd = make_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 8))
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        v3a_result_t want;
        if (!rst_n)
            results_seen <= 0;
        else
        begin
            if (start && !busy)
            begin
                pending_results.push_back(use_typed ? typed_result : vec_result(cmd));
                mode_hits[cmd.mode] = mode_hits[cmd.mode] + 1;
            end
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result x=%h y=%h z=%h status=%0d",
                           result.res_x, result.res_y, result.res_z, result.status);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.res_x !== want.res_x)
                    begin
                        $error("res_x expected %h actual %h", want.res_x, result.res_x);
                        error_count++;
                    end
                    if (result.res_y !== want.res_y)
                    begin
                        $error("res_y expected %h actual %h", want.res_y, result.res_y);
                        error_count++;
                    end
                    if (result.res_z !== want.res_z)
                    begin
                        $error("res_z expected %h actual %h", want.res_z, result.res_z);
                        error_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, result.status);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        v3a_cmd_t c;
        int wait_cycles;
        error_count = 0;
        cycle_count = 0;
        foreach (mode_hits[i])
            mode_hits[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        use_typed = 1'b0;
        typed_result = '0;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row_typed[i] = 1'b0;
            row_result[i] = '0;
        end
        row_cmd[0]  = make_cmd(MODE_ADD, MAX_VAL, MIN_VAL, ONE, ONE, MIN_VAL, ONE, 0);
        row_typed[0] = 1'b1;
        row_result[0] = make_result(MAX_VAL, MIN_VAL, 32'h0002_0000, ST_SAT);
        row_cmd[1]  = make_cmd(MODE_SUB, MIN_VAL, MAX_VAL, 0, ONE, MIN_VAL, 0, 0);
        row_typed[1] = 1'b1;
        row_result[1] = make_result(MIN_VAL, MAX_VAL, 0, ST_SAT);
        row_cmd[2]  = make_cmd(MODE_ADD, 32'h1234_5678, 32'hFFFF_0000, 5, 32'h0000_1111,
                               ONE, 32'hFFFF_FFFB, 0);
        row_cmd[3]  = make_cmd(MODE_SCALE, 0, 0, 0, MAX_VAL, MIN_VAL, ONE, MAX_VAL);
        row_cmd[4]  = make_cmd(MODE_SCALE, 0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 3,
                               32'h0000_8000);
        row_cmd[5]  = make_cmd(MODE_SCALE, 0, 0, 0, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
        row_cmd[6]  = make_cmd(MODE_DOT, ONE, 32'h0002_0000, 32'hFFFF_0000, ONE, ONE, ONE, 0);
        row_cmd[7]  = make_cmd(MODE_DOT, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL,
                               MIN_VAL, 0);
        row_cmd[8]  = make_cmd(MODE_LENGTH, 0, 0, 0, 1, 2, 3, 4);
        row_typed[8] = 1'b1;
        row_result[8] = make_result(0, 0, 0, ST_OK);
        row_cmd[9]  = make_cmd(MODE_LENGTH, ONE, 0, 0, 0, 0, 0, 0);
        row_typed[9] = 1'b1;
        row_result[9] = make_result(ONE, 0, 0, ST_OK);
        row_cmd[10] = make_cmd(MODE_LENGTH, MIN_VAL, MAX_VAL, MIN_VAL, 0, 0, 0, 0);
        row_typed[10] = 1'b1;
        row_result[10] = make_result(MAX_VAL, 0, 0, ST_SAT);
        row_cmd[11] = make_cmd(MODE_LENGTH, 32'h0003_0000, 32'hFFFC_0000, 1, 0, 0, 0, 0);
        row_cmd[12] = make_cmd(MODE_NORM, 0, 0, 0, ONE, ONE, ONE, ONE);
        row_typed[12] = 1'b1;
        row_result[12] = make_result(0, 0, 0, ST_ZERO);
        row_cmd[13] = make_cmd(MODE_NORM, MIN_VAL, 0, 0, 0, 0, 0, 0);
        row_typed[13] = 1'b1;
        row_result[13] = make_result(32'hFFFF_0000, 0, 0, ST_OK);
        row_cmd[14] = make_cmd(MODE_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0, 0);
        row_cmd[15] = make_cmd(MODE_NORM, 1, 0, 0, 0, 0, 0, 0);
        row_cmd[16] = make_cmd(MODE_NORM, MAX_VAL, 1, MIN_VAL, 0, 0, 0, 0);
        row_cmd[17] = make_cmd(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
        row_cmd[18] = make_cmd(MODE_CROSS, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL,
                               MIN_VAL, 0);
        row_cmd[19] = make_cmd(MODE_UNUSED, MAX_VAL, MIN_VAL, ONE, ONE, MAX_VAL, MIN_VAL,
                               MAX_VAL);
        row_typed[19] = 1'b1;
        row_result[19] = make_result(0, 0, 0, ST_OK);

        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            issue(row_cmd[i], row_typed[i], row_result[i]);
            if ($urandom_range(0, 3) == 0)
                idle_burst();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            c = make_cmd(3'($urandom_range(0, 7)), pick_component(), pick_component(),
                         pick_component(), pick_component(), pick_component(),
                         pick_component(), pick_component());
            if ($urandom_range(0, 15) == 0)
            begin
                c.a_x = 0; c.a_y = 0; c.a_z = 0;
            end
            issue(c, 1'b0, '0);
            if (i < N_RANDOM - CALM_TAIL && (i % 200) < 120 && $urandom_range(0, 4) == 0)
                idle_burst();
        end
        start = 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("Sent %0d transactions (%0d directed), checked %0d results.",
                 N_DIRECTED + N_RANDOM, N_DIRECTED, results_seen);
        $display("Per mode add..unused: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
